FILE: hdl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int TIME_W   = 24;
  localparam int DEPTH_W  = 16;
  localparam int POS_W    = 24;
  localparam int ACTION_W = 16;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int FRAC_W   = 16;
  localparam int QUOT_W   = FRAC_W + 1;   // u spans 0..65536

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Word index of the configuration register (paddr[2])
  localparam logic REG_POINT_COUNT = 1'b0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [ACTION_W-1:0] ACTION_NONE = -16'sd1;

  typedef enum logic [2:0] {
    STS_WR_OK      = 3'd0,
    STS_WR_REJECT  = 3'd1,
    STS_INTERP     = 3'd2,
    STS_HELD_FIRST = 3'd3,
    STS_HELD_LAST  = 3'd4,
    STS_EMPTY      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W_RD,
    ST_W_CHK,
    ST_L_RD,
    ST_L_CAP,
    ST_SCAN,
    ST_Q_RDS,
    ST_Q_RDE,
    ST_Q_CAPE,
    ST_DIV,
    ST_LERP,
    ST_FIN
  } state_e;

  // One stored keyframe, apart from its time
  typedef struct packed {
    logic        [DEPTH_W-1:0]  depth;
    logic signed [POS_W-1:0]    x;
    logic signed [POS_W-1:0]    y;
    logic signed [ACTION_W-1:0] action;
  } kf_t;

  // Input tdata layout, last member in the lowest bits
  typedef struct packed {
    logic        [1:0]          pad;
    logic        [TIME_W-1:0]   query_time;
    logic signed [ACTION_W-1:0] key_action;
    logic signed [POS_W-1:0]    key_y;
    logic signed [POS_W-1:0]    key_x;
    logic        [DEPTH_W-1:0]  key_depth;
    logic        [TIME_W-1:0]   key_time;
    logic        [INDEX_W-1:0]  point_index;
  } in_data_t;

  // Output tdata layout, last member in the lowest bits
  typedef struct packed {
    logic        [TIME_W-1:0]   lifetime;
    logic signed [ACTION_W-1:0] out_action;
    logic signed [POS_W-1:0]    out_y;
    logic signed [POS_W-1:0]    out_x;
    logic        [DEPTH_W-1:0]  out_depth;
    logic        [TIME_W-1:0]   out_time;
  } out_data_t;

  typedef struct packed {
    status_e   status;
    out_data_t data;
  } result_t;

endpackage

FILE: hdl/kti_ram.sv
// ----------------------------------------------------------------------------
// kti_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/kti_div.sv
// ----------------------------------------------------------------------------
// kti_div
// Restoring divider, one quotient bit per cycle, for the Q1.16 fraction
// u = (diff << 16) / den with diff <= den.
// ----------------------------------------------------------------------------
module kti_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kti_pkg::TIME_W-1:0]   dividend,
  input  logic [kti_pkg::TIME_W-1:0]   divisor,
  output logic                         busy,
  output logic [kti_pkg::QUOT_W-1:0]   quot
);

  localparam int TW = kti_pkg::TIME_W;
  localparam int QW = kti_pkg::QUOT_W;
  localparam int CW = $clog2(QW + 1);

  logic [TW-1:0] rem;
  logic [TW-1:0] den;
  logic [QW-1:0] bits;
  logic [CW-1:0] cnt;
  logic [TW:0]   trial;
  logic          ge;

  // diff <= den, so diff >> 1 already sits below den as the first remainder
  assign trial = {rem, bits[QW-1]};
  assign ge    = trial >= {1'b0, den};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dividend[TW-1:1]};
      bits <= {dividend[0], {(QW-1){1'b0}}};
      den  <= divisor;
    end else if (busy) begin
      rem  <= ge ? TW'(trial - {1'b0, den}) : trial[TW-1:0];
      bits <= {bits[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

FILE: hdl/kti_lerp.sv
// ----------------------------------------------------------------------------
// kti_lerp
// Three-stage linear blend: y = a + round_half_up(u * (b - a) / 65536).
// ----------------------------------------------------------------------------
module kti_lerp #(
  parameter int W = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic signed [W-1:0]         a,
  input  logic signed [W-1:0]         b,
  input  logic [kti_pkg::QUOT_W-1:0]  u,
  output logic                        out_vld,
  output logic signed [W-1:0]         y
);

  localparam int PW = W + kti_pkg::QUOT_W + 2;

  logic [2:0]                    vld;
  logic signed [W:0]             diff;
  logic signed [W-1:0]           a1;
  logic signed [W-1:0]           a2;
  logic [kti_pkg::QUOT_W-1:0]    u1;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          rnd;

  assign rnd     = (prod + PW'(32768)) >>> kti_pkg::FRAC_W;
  assign out_vld = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    diff <= (W+1)'(b) - (W+1)'(a);
    a1   <= a;
    u1   <= u;
    prod <= PW'(diff) * PW'($signed({1'b0, u1}));
    a2   <= a1;
    y    <= W'(PW'(a2) + rnd);
  end

endmodule

FILE: hdl/keyframe_track_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Keyframe table with ordered loading and piecewise linear sampling.
// ----------------------------------------------------------------------------
// One transaction in, one result out, one item at a time. A write (tuser 0)
// reads the previous slot, checks time order and trigger repeat, stores the
// key and re-reads the last key time for lifetime. A query (tuser 1) scans
// the key times through the time RAM read port, one key per cycle, up to the
// first key at or past the query time (k keys visited), then fetches the
// bracketing keys. Interpolated results then pass the bit-serial divider that
// forms u and the 3-stage blend pipeline. A finished result waits in the
// output register, and the next transaction is taken while it waits. There
// is no clearing pass after reset: slots read before they were written
// return garbage.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator #(
  parameter int MAX_POINTS = kti_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kti_pkg::PADDR_W-1:0]  paddr,
  input  logic [kti_pkg::PDATA_W-1:0]  pwdata,
  output logic [kti_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // point_index[5:0], key_time[29:6], key_depth[45:30], key_x[69:46],
  // key_y[93:70], key_action[109:94], query_time[133:110], zero[135:134]
  input  logic [135:0]                 s_tdata,
  // cmd[0]
  input  logic [0:0]                   s_tuser,
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_time[23:0], out_depth[39:24], out_x[63:40], out_y[87:64],
  // out_action[103:88], lifetime[127:104]
  output logic [127:0]                 m_tdata,
  // status[2:0]
  output logic [2:0]                   m_tuser
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = kti_pkg::TIME_W;
  localparam int KW = $bits(kti_pkg::kf_t);

  kti_pkg::state_e   state, state_next;
  kti_pkg::in_data_t item;
  logic              item_cmd;
  kti_pkg::result_t  res;
  kti_pkg::kf_t      sdata, edata;

  logic [kti_pkg::COUNT_W-1:0] point_count;
  logic [CW-1:0]               n_cnt;
  logic [AW-1:0]               n_m1;

  // RAM ports
  logic          t_we, d_we;
  logic [AW-1:0] waddr, t_raddr, d_raddr;
  logic [TW-1:0] t_rdata;
  logic [KW-1:0] d_rdata_raw;
  kti_pkg::kf_t  d_rdata;
  kti_pkg::kf_t  d_wdata;

  // scan bookkeeping
  logic [CW-1:0] iss;
  logic          rd_vld;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] s_idx, e_idx;
  logic [TW-1:0] s_time, e_time;
  logic          hs;
  logic          scan_gt, scan_done;

  logic          s_acc, cfg_wr, out_free, wr_ok, in_range;
  logic          div_start, div_busy;
  logic [kti_pkg::QUOT_W-1:0] u;
  logic          lerp_start;
  logic          lerp_vld, lerp_vx, lerp_vy;
  logic signed [kti_pkg::DEPTH_W:0]  lerp_d;
  logic signed [kti_pkg::POS_W-1:0]  lerp_x, lerp_y;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == kti_pkg::REG_POINT_COUNT)
                  ? kti_pkg::PDATA_W'(point_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_wr && paddr[2] == kti_pkg::REG_POINT_COUNT) begin
      point_count <= pwdata[kti_pkg::COUNT_W-1:0];
    end
  end

  // keys in use, saturated to the table size
  assign n_cnt = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign n_m1  = AW'(n_cnt - CW'(1));

  // --------------------------------------------------------------------------
  // Keyframe storage: times in one RAM, depth/x/y/action in the other
  // --------------------------------------------------------------------------
  kti_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (waddr),
    .wdata (item.key_time),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kti_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata_raw)
  );

  assign d_rdata = kti_pkg::kf_t'(d_rdata_raw);
  assign d_wdata = '{depth: item.key_depth, x: item.key_x, y: item.key_y,
                     action: item.key_action};
  assign waddr   = AW'(item.point_index);

  // write check against the previous slot (slot 0 has none)
  assign in_range = 32'(item.point_index) < MAX_POINTS;
  assign wr_ok = in_range &&
                 (item.point_index == '0 ||
                  (item.key_time > t_rdata &&
                   !(d_rdata.action != kti_pkg::ACTION_NONE &&
                     d_rdata.action == item.key_action)));

  assign t_we = (state == kti_pkg::ST_W_CHK) && wr_ok;
  assign d_we = t_we;

  // --------------------------------------------------------------------------
  // Scan: one time per cycle, result of a read seen in the cycle after issue
  // --------------------------------------------------------------------------
  assign scan_gt   = item.query_time > t_rdata;
  assign scan_done = (state == kti_pkg::ST_SCAN) && rd_vld &&
                     (!scan_gt || rd_idx == n_cnt - CW'(1));
  assign div_start = scan_done && !scan_gt && hs;

  kti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.query_time - s_time),
    .divisor  (t_rdata - s_time),
    .busy     (div_busy),
    .quot     (u)
  );

  // --------------------------------------------------------------------------
  // Blend units, one each for depth, x and y
  // --------------------------------------------------------------------------
  assign lerp_start = (state == kti_pkg::ST_DIV) && !div_busy;

  kti_lerp #(.W(kti_pkg::DEPTH_W + 1)) u_lerp_d (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (lerp_start),
    .a       ($signed({1'b0, sdata.depth})),
    .b       ($signed({1'b0, edata.depth})),
    .u       (u),
    .out_vld (lerp_vld),
    .y       (lerp_d)
  );

  kti_lerp #(.W(kti_pkg::POS_W)) u_lerp_x (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (lerp_start),
    .a       (sdata.x),
    .b       (edata.x),
    .u       (u),
    .out_vld (lerp_vx),
    .y       (lerp_x)
  );

  kti_lerp #(.W(kti_pkg::POS_W)) u_lerp_y (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (lerp_start),
    .a       (sdata.y),
    .b       (edata.y),
    .u       (u),
    .out_vld (lerp_vy),
    .y       (lerp_y)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kti_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    t_raddr    = '0;
    d_raddr    = '0;
    unique case (state)
      kti_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc) begin
          if (s_tuser[0] == kti_pkg::CMD_WRITE) begin
            state_next = kti_pkg::ST_W_RD;
          end else if (n_cnt == '0) begin
            state_next = kti_pkg::ST_FIN;
          end else begin
            state_next = kti_pkg::ST_SCAN;
          end
        end
      end
      kti_pkg::ST_W_RD: begin
        t_raddr    = AW'(item.point_index - kti_pkg::INDEX_W'(1));
        d_raddr    = t_raddr;
        state_next = kti_pkg::ST_W_CHK;
      end
      kti_pkg::ST_W_CHK: begin
        state_next = kti_pkg::ST_L_RD;
      end
      kti_pkg::ST_L_RD: begin
        t_raddr    = n_m1;
        state_next = kti_pkg::ST_L_CAP;
      end
      kti_pkg::ST_L_CAP: begin
        state_next = kti_pkg::ST_FIN;
      end
      kti_pkg::ST_SCAN: begin
        t_raddr = iss[AW-1:0];
        if (scan_done) begin
          state_next = kti_pkg::ST_Q_RDS;
        end
      end
      kti_pkg::ST_Q_RDS: begin
        t_raddr    = n_m1;
        d_raddr    = (res.status == kti_pkg::STS_HELD_FIRST) ? e_idx[AW-1:0]
                                                             : s_idx[AW-1:0];
        state_next = kti_pkg::ST_Q_RDE;
      end
      kti_pkg::ST_Q_RDE: begin
        d_raddr    = e_idx[AW-1:0];
        state_next = (res.status == kti_pkg::STS_INTERP) ? kti_pkg::ST_Q_CAPE
                                                         : kti_pkg::ST_FIN;
      end
      kti_pkg::ST_Q_CAPE: begin
        state_next = kti_pkg::ST_DIV;
      end
      kti_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_next = kti_pkg::ST_LERP;
        end
      end
      kti_pkg::ST_LERP: begin
        if (lerp_vld) begin
          state_next = kti_pkg::ST_FIN;
        end
      end
      kti_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = kti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kti_pkg::ST_IDLE;
      end
    endcase
  end

  // scan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      iss    <= '0;
      rd_vld <= 1'b0;
      hs     <= 1'b0;
    end else if (s_acc) begin
      iss    <= '0;
      rd_vld <= 1'b0;
      hs     <= 1'b0;
    end else if (state == kti_pkg::ST_SCAN) begin
      if (iss < n_cnt) begin
        iss    <= iss + CW'(1);
        rd_vld <= 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
      if (rd_vld && scan_gt) begin
        hs <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      item     <= kti_pkg::in_data_t'(s_tdata);
      item_cmd <= s_tuser[0];
      if (s_tuser[0] == kti_pkg::CMD_QUERY) begin
        res <= '{status: kti_pkg::STS_EMPTY, data: '0};
      end
    end
    unique case (state)
      kti_pkg::ST_W_CHK: begin
        res.status          <= wr_ok ? kti_pkg::STS_WR_OK : kti_pkg::STS_WR_REJECT;
        res.data.out_time   <= item.key_time;
        res.data.out_depth  <= item.key_depth;
        res.data.out_x      <= item.key_x;
        res.data.out_y      <= item.key_y;
        res.data.out_action <= item.key_action;
      end
      kti_pkg::ST_L_CAP: begin
        res.data.lifetime <= (n_cnt == '0) ? '0 : t_rdata;
      end
      kti_pkg::ST_SCAN: begin
        if (iss < n_cnt) begin
          rd_idx <= iss;
        end
        if (rd_vld) begin
          if (scan_gt) begin
            s_idx  <= rd_idx;
            s_time <= t_rdata;
          end else begin
            e_idx  <= rd_idx;
            e_time <= t_rdata;
          end
        end
        if (scan_done) begin
          res.status <= scan_gt ? kti_pkg::STS_HELD_LAST
                      : (hs ? kti_pkg::STS_INTERP : kti_pkg::STS_HELD_FIRST);
        end
      end
      kti_pkg::ST_Q_RDE: begin
        sdata             <= d_rdata;
        res.data.lifetime <= t_rdata;
        res.data.out_time <= (res.status == kti_pkg::STS_HELD_FIRST) ? e_time : s_time;
        res.data.out_depth  <= d_rdata.depth;
        res.data.out_x      <= d_rdata.x;
        res.data.out_y      <= d_rdata.y;
        res.data.out_action <= d_rdata.action;
      end
      kti_pkg::ST_Q_CAPE: begin
        edata <= d_rdata;
      end
      kti_pkg::ST_LERP: begin
        if (lerp_vld) begin
          res.data.out_time   <= item.query_time;
          res.data.out_depth  <= lerp_d[kti_pkg::DEPTH_W-1:0];
          res.data.out_x      <= lerp_x;
          res.data.out_y      <= lerp_y;
          res.data.out_action <= sdata.action;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == kti_pkg::ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kti_pkg::ST_FIN && out_free) begin
      m_tdata <= res.data;
      m_tuser <= res.status;
    end
  end

`ifndef SYNTHESIS
  // table is only written on a checked write transaction
  a_write_on_cmd: assert property (@(posedge clk) disable iff (rst)
    t_we |-> (state == kti_pkg::ST_W_CHK && item_cmd == kti_pkg::CMD_WRITE))
    else $error("keyframe write outside a write transaction");

  // divider never restarted while a fraction is in flight
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // blend results only show up while the sequencer waits for them
  a_lerp_when_waiting: assert property (@(posedge clk) disable iff (rst)
    (lerp_vld || lerp_vx || lerp_vy) |-> (state == kti_pkg::ST_LERP))
    else $error("blend result arrived outside the blend wait");

  // a held result is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == kti_pkg::ST_FIN && m_tvalid && !m_tready) |=> state == kti_pkg::ST_FIN)
    else $error("result dropped while output register full");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe track interpolator.
// ----------------------------------------------------------------------------
// A directed table first walks the corner cases: empty track, rejected
// writes, held first/last, exact key hits and an out-of-order table. Then
// random phases load a track in time order (with the odd broken write), set
// the point count over APB, and mix queries with further writes. Every
// transaction is run through a local track model at issue time; results are
// checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  import kti_pkg::*;

  localparam int TAB_DEPTH   = MAX_POINTS_DEF;
  localparam int RAND_ITEMS  = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_AFTER  = 60;    // results seen before the long stall
  localparam int HOLD_LEN    = 600;   // cycles of m_tready low
  localparam int DIR_ROWS    = 24;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {RK_WRITE, RK_QUERY, RK_CFG} row_kind_e;

  // one directed row; qt carries the count for RK_CFG rows
  typedef struct {
    row_kind_e kind;
    int        idx, tm, dp, px, py, ac, qt;
    bit        chk;
    status_e   w_st;
    int        w_tm, w_dp, w_px, w_py, w_ac, w_lt;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_tvalid;
  logic                s_tready;
  logic [135:0]        s_tdata;
  logic [0:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [127:0]        m_tdata;
  logic [2:0]          m_tuser;

  // track model state
  logic [TIME_W-1:0]   kf_time_tab [TAB_DEPTH];
  kf_t                 kf_val_tab  [TAB_DEPTH];
  logic [COUNT_W-1:0]  count_reg;
  int                  loaded_len;   // slots below this hold a written key
  result_t             track_expect_q[$];

  int sent_cnt, seen_cnt, err_cnt, cycle_cnt;
  int tx_idle_pct, rx_idle_pct;
  int hold_left;
  bit hold_done;
  result_t got, want_now;

  keyframe_track_interpolator dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Track model
  // ---------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] track_lifetime();
    int n;
    n = (count_reg > TAB_DEPTH) ? TAB_DEPTH : int'(count_reg);
    return (n == 0) ? '0 : kf_time_tab[n-1];
  endfunction

  // round-half-up blend of a and b by u/65536
  function automatic longint blend(longint a, longint b, longint u);
    return ((65536 - u) * a + u * b + 32768) >>> 16;
  endfunction

  // Expected result of one transaction; updates the model's table.
  function automatic result_t predict_track(logic cmd, in_data_t d);
    result_t r;
    int      n, s, e, i, pick;
    bit      hs, he, ok;
    longint  u, ts, te;
    kf_t     ka, kb;
    r = '0;
    if (cmd == CMD_WRITE) begin
      ok = 1'b1;
      // slot 0 has no predecessor to check against
      if (d.point_index > 0) begin
        if (d.key_time <= kf_time_tab[d.point_index - 1]) ok = 1'b0;
        if (kf_val_tab[d.point_index - 1].action != ACTION_NONE &&
            kf_val_tab[d.point_index - 1].action == d.key_action) ok = 1'b0;
      end
      if (ok) begin
        kf_time_tab[d.point_index] = d.key_time;
        kf_val_tab[d.point_index]  = '{depth: d.key_depth, x: d.key_x,
                                       y: d.key_y, action: d.key_action};
        if (int'(d.point_index) == loaded_len) loaded_len++;
      end
      r.status          = ok ? STS_WR_OK : STS_WR_REJECT;
      r.data.out_time   = d.key_time;
      r.data.out_depth  = d.key_depth;
      r.data.out_x      = d.key_x;
      r.data.out_y      = d.key_y;
      r.data.out_action = d.key_action;
      r.data.lifetime   = track_lifetime();
      return r;
    end

    n = (count_reg > TAB_DEPTH) ? TAB_DEPTH : int'(count_reg);
    if (n == 0) begin
      r.status = STS_EMPTY;
      return r;
    end
    // scan stops at the first key at or past the query time
    s = 0; e = 0; hs = 1'b0; he = 1'b0;
    for (i = 0; i < n && !he; i++) begin
      if (d.query_time > kf_time_tab[i]) begin
        s = i; hs = 1'b1;
      end else begin
        e = i; he = 1'b1;
      end
    end
    r.data.lifetime = track_lifetime();
    if (!he || !hs) begin
      r.status = !he ? STS_HELD_LAST : STS_HELD_FIRST;
      pick = !he ? s : e;
      r.data.out_time   = kf_time_tab[pick];
      r.data.out_depth  = kf_val_tab[pick].depth;
      r.data.out_x      = kf_val_tab[pick].x;
      r.data.out_y      = kf_val_tab[pick].y;
      r.data.out_action = kf_val_tab[pick].action;
      return r;
    end
    ts = kf_time_tab[s];
    te = kf_time_tab[e];
    u  = (te > ts) ? ((longint'(d.query_time) - ts) <<< 16) / (te - ts) : 0;
    if (u > 65536) u = 65536;
    ka = kf_val_tab[s];
    kb = kf_val_tab[e];
    r.status          = STS_INTERP;
    r.data.out_time   = d.query_time;
    r.data.out_depth  = DEPTH_W'(blend(longint'(ka.depth), longint'(kb.depth), u));
    r.data.out_x      = POS_W'(blend(longint'($signed(ka.x)), longint'($signed(kb.x)), u));
    r.data.out_y      = POS_W'(blend(longint'($signed(ka.y)), longint'($signed(kb.y)), u));
    r.data.out_action = ka.action;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [ACTION_W-1:0] random_action();
    return ($urandom_range(0, 3) == 0) ? ACTION_NONE : ACTION_W'($urandom_range(0, 32767));
  endfunction

  function automatic in_data_t random_payload();
    in_data_t d;
    d             = '0;
    d.point_index = INDEX_W'($urandom);
    d.key_time    = TIME_W'($urandom);
    d.key_depth   = DEPTH_W'($urandom);
    d.key_x       = POS_W'($urandom);
    d.key_y       = POS_W'($urandom);
    d.key_action  = random_action();
    d.query_time  = TIME_W'($urandom);
    return d;
  endfunction

  // Key for a slot, later in time than its predecessor with room left for
  // 'left' more keys; broken keys repeat the trigger or are not later in time.
  function automatic in_data_t make_key(int slot, int left, bit broken);
    in_data_t                   d;
    int                         prev_t, span;
    logic signed [ACTION_W-1:0] prev_a;
    d = random_payload();
    d.point_index = INDEX_W'(slot);
    if (slot == 0) begin
      d.key_time = TIME_W'($urandom_range(0, TIME_MAX / 2));
      return d;
    end
    prev_t = kf_time_tab[slot-1];
    prev_a = kf_val_tab[slot-1].action;
    span   = (int'(TIME_MAX) - prev_t) / left;
    d.key_time = TIME_W'(prev_t + $urandom_range(1, span > 1 ? span : 1));
    if (d.key_action == prev_a && prev_a != ACTION_NONE) d.key_action = ACTION_NONE;
    if (broken) begin
      if (prev_a != ACTION_NONE && $urandom_range(0, 1) == 1) d.key_action = prev_a;
      else d.key_time = TIME_W'(prev_t - $urandom_range(0, prev_t < 1000 ? prev_t : 1000));
    end
    return d;
  endfunction

  // Mostly inside the track's span, some exact key hits, some outside.
  function automatic logic [TIME_W-1:0] pick_query_time(int cnt);
    int n, lo, hi, sel;
    n = (cnt > TAB_DEPTH) ? TAB_DEPTH : cnt;
    if (n == 0) return TIME_W'($urandom);
    lo = kf_time_tab[0];
    hi = kf_time_tab[n-1];
    if (lo > hi) begin
      sel = lo; lo = hi; hi = sel;
    end
    sel = $urandom_range(0, 19);
    if (sel < 12) return TIME_W'($urandom_range(lo, hi));
    if (sel < 15) return TIME_W'(kf_time_tab[$urandom_range(0, n - 1)] + $urandom_range(0, 1));
    if (sel < 17) return TIME_W'($urandom_range(0, lo));
    return TIME_W'($urandom);
  endfunction

  // Offer one transaction; called and returns at a falling edge.
  task automatic offer_item(logic cmd, in_data_t d, result_t want);
    track_expect_q.push_back(want);
    // idle mix: receiver-heavy gaps, then sender-heavy, then none
    if (sent_cnt < 150) begin
      tx_idle_pct = 24; rx_idle_pct = 75;
    end else if (sent_cnt < 290) begin
      tx_idle_pct = 75; rx_idle_pct = 24;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent_cnt++;
  endtask

  // APB write of point_count once every pending result is back
  task automatic set_point_count(int value);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (track_expect_q.size() != 0) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_POINT_COUNT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    count_reg = COUNT_W'(value);
  endtask

  task automatic note_mismatch(string what, longint gv, longint wv);
    err_cnt++;
    if (err_cnt <= 40)
      $display("result %0d: %s mismatch, got 0x%0h, expected 0x%0h", seen_cnt, what, gv, wv);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random m_tready, plus one long stall to back up the input
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && seen_cnt >= HOLD_AFTER) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // result checker: in order against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_cnt++;
      got = {m_tuser, m_tdata};
      if (track_expect_q.size() == 0) begin
        note_mismatch("unexpected result, status", got.status, 0);
      end else begin
        want_now = track_expect_q.pop_front();
        if (got.status !== want_now.status)
          note_mismatch("status", got.status, want_now.status);
        if (got.data.out_time !== want_now.data.out_time)
          note_mismatch("out_time", got.data.out_time, want_now.data.out_time);
        if (got.data.out_depth !== want_now.data.out_depth)
          note_mismatch("out_depth", got.data.out_depth, want_now.data.out_depth);
        if (got.data.out_x !== want_now.data.out_x)
          note_mismatch("out_x", got.data.out_x, want_now.data.out_x);
        if (got.data.out_y !== want_now.data.out_y)
          note_mismatch("out_y", got.data.out_y, want_now.data.out_y);
        if (got.data.out_action !== want_now.data.out_action)
          note_mismatch("out_action", got.data.out_action, want_now.data.out_action);
        if (got.data.lifetime !== want_now.data.lifetime)
          note_mismatch("lifetime", got.data.lifetime, want_now.data.lifetime);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t dir_tab [DIR_ROWS];
    in_data_t  d;
    result_t   want;
    logic      cmd;
    int        rand_goal, phase, k, n, m, i, slot;
    bit        big;

    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_WRITE;
    foreach (kf_time_tab[j]) begin
      kf_time_tab[j] = '0;
      kf_val_tab[j]  = '0;
    end
    count_reg   = '0;
    loaded_len  = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 75;

    // kind, idx, time, depth, x, y, action, query/count,
    //   check, status, time, depth, x, y, action, lifetime
    dir_tab = '{
      // empty track right after reset
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 16777215,
        1, STS_EMPTY, 0, 0, 0, 0, 0, 0},
      // first key with position extremes, no trigger
      '{RK_WRITE, 0, 100, 0, -8388608, 8388607, -1, 0,
        1, STS_WR_OK, 100, 0, -8388608, 8388607, -1, 0},
      // same time as predecessor, then earlier time: both rejected
      '{RK_WRITE, 1, 100, 1, 1, 1, 5, 0,
        1, STS_WR_REJECT, 100, 1, 1, 1, 5, 0},
      '{RK_WRITE, 1, 50, 2, 2, 2, 5, 0,
        1, STS_WR_REJECT, 50, 2, 2, 2, 5, 0},
      // repeating "no trigger" is fine
      '{RK_WRITE, 1, 1100, 65535, 8388607, -8388608, -1, 0,
        1, STS_WR_OK, 1100, 65535, 8388607, -8388608, -1, 0},
      '{RK_WRITE, 2, 2100, 1000, 256, -256, 7, 0,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // repeated trigger id is rejected
      '{RK_WRITE, 3, 3000, 0, 0, 0, 7, 0,
        1, STS_WR_REJECT, 3000, 0, 0, 0, 7, 0},
      '{RK_WRITE, 3, 16777214, 40000, -1, 1, 32767, 0,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      '{RK_CFG, 0, 0, 0, 0, 0, 0, 4,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // before and at the first key: hold first
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 0,
        1, STS_HELD_FIRST, 100, 0, -8388608, 8388607, -1, 16777214},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 100,
        1, STS_HELD_FIRST, 100, 0, -8388608, 8388607, -1, 16777214},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 600,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // exactly on an inner key: u hits one
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 1100,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // past the last key: hold last
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 16777215,
        1, STS_HELD_LAST, 16777214, 40000, -1, 1, 32767, 16777214},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 2101,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // single key track
      '{RK_CFG, 0, 0, 0, 0, 0, 0, 1,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 50,
        1, STS_HELD_FIRST, 100, 0, -8388608, 8388607, -1, 100},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 5000,
        1, STS_HELD_LAST, 100, 0, -8388608, 8388607, -1, 100},
      '{RK_CFG, 0, 0, 0, 0, 0, 0, 4,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // rewrite slot 1 late so slot 2 falls behind it: unordered table
      '{RK_WRITE, 1, 5000000, 123, -5000, 7000, 9, 0,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 3000,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 5000001,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      // slot 0 at time zero, never checked against a predecessor
      '{RK_WRITE, 0, 0, 65535, 0, 0, 0, 0,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0},
      '{RK_QUERY, 0, 0, 0, 0, 0, 0, 1,
        0, STS_WR_OK, 0, 0, 0, 0, 0, 0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == RK_CFG) begin
        set_point_count(dir_tab[r].qt);
      end else begin
        d             = '0;
        d.point_index = INDEX_W'(dir_tab[r].idx);
        d.key_time    = TIME_W'(dir_tab[r].tm);
        d.key_depth   = DEPTH_W'(dir_tab[r].dp);
        d.key_x       = POS_W'(dir_tab[r].px);
        d.key_y       = POS_W'(dir_tab[r].py);
        d.key_action  = ACTION_W'(dir_tab[r].ac);
        d.query_time  = TIME_W'(dir_tab[r].qt);
        cmd  = (dir_tab[r].kind == RK_QUERY) ? CMD_QUERY : CMD_WRITE;
        want = predict_track(cmd, d);
        if (dir_tab[r].chk) begin
          want.status          = dir_tab[r].w_st;
          want.data.out_time   = TIME_W'(dir_tab[r].w_tm);
          want.data.out_depth  = DEPTH_W'(dir_tab[r].w_dp);
          want.data.out_x      = POS_W'(dir_tab[r].w_px);
          want.data.out_y      = POS_W'(dir_tab[r].w_py);
          want.data.out_action = ACTION_W'(dir_tab[r].w_ac);
          want.data.lifetime   = TIME_W'(dir_tab[r].w_lt);
        end
        offer_item(cmd, d, want);
      end
    end

    // random phases: load a track, set the count, then mostly queries
    rand_goal = sent_cnt + RAND_ITEMS;
    phase     = 0;
    while (sent_cnt < rand_goal) begin
      big = (phase == 1 || phase == 8);
      k   = big ? TAB_DEPTH : $urandom_range(2, 8);
      // a slot is only written once its predecessor holds a key
      for (i = 0; i < k && i <= loaded_len; i++) begin
        if (i > 0 && $urandom_range(0, 7) == 0) begin
          d = make_key(i, k - i, 1'b1);
          offer_item(CMD_WRITE, d, predict_track(CMD_WRITE, d));
        end
        d = make_key(i, k - i, 1'b0);
        offer_item(CMD_WRITE, d, predict_track(CMD_WRITE, d));
      end

      // count never exceeds the written prefix, but the full table of phase 1
      // gets the over-range count, which must saturate
      if (big) begin
        n = (loaded_len < TAB_DEPTH) ? loaded_len : (phase == 1) ? 127 : TAB_DEPTH;
      end else begin
        case ($urandom_range(0, 9))
          0:       n = 0;
          1:       n = $urandom_range(1, loaded_len);
          2:       n = loaded_len;
          default: n = (k < loaded_len) ? k : loaded_len;
        endcase
      end
      set_point_count(n);

      m = big ? 40 : $urandom_range(8, 24);
      for (i = 0; i < m; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          slot = $urandom_range(0, (loaded_len < TAB_DEPTH) ? loaded_len : TAB_DEPTH - 1);
          if ($urandom_range(0, 3) == 0) begin
            d             = random_payload();
            d.point_index = INDEX_W'(slot);
          end else begin
            d = make_key(slot, 1 + $urandom_range(0, 3), $urandom_range(0, 3) == 0);
          end
          offer_item(CMD_WRITE, d, predict_track(CMD_WRITE, d));
        end else begin
          d            = random_payload();
          d.query_time = pick_query_time(n);
          offer_item(CMD_QUERY, d, predict_track(CMD_QUERY, d));
        end
      end
      phase++;
    end

    // drain, then give stray results time to show up
    s_tvalid <= 1'b0;
    while (track_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/kti_pkg.sv
hdl/kti_ram.sv
hdl/kti_div.sv
hdl/kti_lerp.sv
hdl/keyframe_track_interpolator.sv
tb/tb.sv
